@@ hw/rtl/fixed_pattern_stream_matcher_defines.svh @@
// assertion helpers for the pattern matcher
`ifndef FIXED_PATTERN_STREAM_MATCHER_DEFINES_SVH
`define FIXED_PATTERN_STREAM_MATCHER_DEFINES_SVH

// same-cycle implication
`define FPSM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fpsm check failed");

// next-cycle implication
`define FPSM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fpsm check failed");

`endif

@@ hw/rtl/fpsm_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package fpsm_pkg;

  localparam int MAX_PATTERN_BYTES = 32;
  localparam int PLEN_W = 6;
  localparam int POS_W = 32;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 64;
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QUEUE_CW = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_PATTERN_LENGTH  = 3'd0,
    REG_MATCH_CASE      = 3'd1,
    REG_PATTERN_0_7     = 3'd2,
    REG_PATTERN_8_15    = 3'd3,
    REG_PATTERN_16_23   = 3'd4,
    REG_PATTERN_24_31   = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic             last;
    logic [POS_W-1:0] offset;
    logic             hit;
  } entry_t;

  // ascii upper case to lower case
  function automatic logic [7:0] fold_byte(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/fixed_pattern_stream_matcher.sv @@
// an accepted byte's result is written into a queue slot, then into the output register
// throughput: one byte per cycle while the queue is not full, set by the history update in the front
// a two-entry queue and the output register let both sides stall on their own
// reset (rst, synchronous): clears history, position, count, queue and output valid;
// pattern length returns to 1, exact compare, pattern bytes to zero
`timescale 1ns / 1ps
`default_nettype none
`include "fixed_pattern_stream_matcher_defines.svh"
module fixed_pattern_stream_matcher #(
  parameter int MAX_PATTERN_BYTES = fpsm_pkg::MAX_PATTERN_BYTES
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [fpsm_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [fpsm_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  input  wire logic [7:0]                      s_tdata,  // data_byte
  input  wire logic                            s_tlast,
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  output logic [63:0]                          m_tdata,  // match_offset, match_count
  output logic                                 m_tuser,  // hit
  output logic                                 m_tlast
);

  fpsm_pkg::entry_t push_entry;
  fpsm_pkg::entry_t head;
  logic             accept;
  logic             q_valid;
  logic             q_full;
  logic             q_pop;

  assign s_tready = !q_full;
  assign accept = s_tvalid && s_tready;

  fpsm_front #(
    .MAX_PATTERN_BYTES(MAX_PATTERN_BYTES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .data_byte (s_tdata),
    .last_byte (s_tlast),
    .entry     (push_entry)
  );

  fpsm_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (accept),
    .push_entry (push_entry),
    .pop        (q_pop),
    .head       (head),
    .valid      (q_valid),
    .full       (q_full)
  );

  fpsm_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (q_valid),
    .pop        (q_pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast)
  );

  `FPSM_ASSERT_NOW(a_hit_has_count, m_tvalid && m_tuser, m_tdata[63:32] != 32'd0)
  `FPSM_ASSERT_NEXT(a_pop_fills_output, q_pop, m_tvalid)
  `FPSM_ASSERT_NOW(a_no_pop_when_stalled, m_tvalid && !m_tready, !q_pop)
  `FPSM_ASSERT_NOW(a_pop_needs_entry, q_pop, q_valid)

endmodule
`default_nettype wire

@@ hw/rtl/fpsm_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
module fpsm_front #(
  parameter int MAX_PATTERN_BYTES = fpsm_pkg::MAX_PATTERN_BYTES
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [fpsm_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [fpsm_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                            accept,
  input  wire logic [7:0]                      data_byte,
  input  wire logic                            last_byte,
  output fpsm_pkg::entry_t                     entry
);

  localparam int PLEN_W = fpsm_pkg::PLEN_W;
  localparam int POS_W = fpsm_pkg::POS_W;

  logic [PLEN_W-1:0]            pattern_length;
  logic                         match_case;
  logic [7:0]                   pattern [MAX_PATTERN_BYTES];
  logic [MAX_PATTERN_BYTES-1:0] hist;
  logic [POS_W-1:0]             pos;

  logic [PLEN_W-1:0]            eff_len;
  logic [7:0]                   cmp_byte;
  logic [MAX_PATTERN_BYTES-1:0] eq;
  logic [MAX_PATTERN_BYTES-1:0] sel;
  logic [MAX_PATTERN_BYTES-1:0] hist_next;
  logic                         hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length <= PLEN_W'(1);
      match_case <= 1'b1;
    end else if (cfg_we) begin
      if (cfg_addr == fpsm_pkg::REG_PATTERN_LENGTH) begin
        pattern_length <= cfg_data[PLEN_W-1:0];
      end
      if (cfg_addr == fpsm_pkg::REG_MATCH_CASE) begin
        match_case <= cfg_data[0];
      end
    end
  end

  for (genvar i = 0; i < MAX_PATTERN_BYTES; i++) begin : g_pat
    localparam logic [fpsm_pkg::CFG_ADDR_W-1:0] WORD_ADDR =
      fpsm_pkg::CFG_ADDR_W'(int'(fpsm_pkg::REG_PATTERN_0_7) + i / 8);
    localparam int LANE = (i % 8) * 8;

    always_ff @(posedge clk) begin
      if (rst) begin
        pattern[i] <= 8'h00;
      end else if (cfg_we && cfg_addr == WORD_ADDR) begin
        pattern[i] <= cfg_data[LANE +: 8];
      end
    end

    always_comb begin
      eq[i] = (match_case ? pattern[i] : fpsm_pkg::fold_byte(pattern[i])) == cmp_byte;
      sel[i] = (eff_len == PLEN_W'(i + 1));
    end
  end

  always_comb begin
    eff_len = (pattern_length > PLEN_W'(MAX_PATTERN_BYTES)) ?
              PLEN_W'(MAX_PATTERN_BYTES) : pattern_length;
    cmp_byte = match_case ? data_byte : fpsm_pkg::fold_byte(data_byte);
    hist_next = ((hist << 1) | MAX_PATTERN_BYTES'(1)) & eq;
    hit = |(hist_next & sel);
    entry.hit = hit;
    entry.offset = hit ? (pos - POS_W'(eff_len) + POS_W'(1)) : '0;
    entry.last = last_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hist <= '0;
      pos <= '0;
    end else if (accept) begin
      hist <= last_byte ? '0 : hist_next;
      pos <= last_byte ? '0 : pos + POS_W'(1);
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/fpsm_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
module fpsm_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire fpsm_pkg::entry_t push_entry,
  input  wire logic             pop,
  output fpsm_pkg::entry_t      head,
  output logic                  valid,
  output logic                  full
);

  localparam int AW = fpsm_pkg::QUEUE_AW;
  localparam int CW = fpsm_pkg::QUEUE_CW;
  localparam int DEPTH = fpsm_pkg::QUEUE_DEPTH;

  fpsm_pkg::entry_t slots [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  function automatic logic [AW-1:0] bump(input logic [AW-1:0] p);
    logic [AW-1:0] r;
    r = (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
    return r;
  endfunction

  assign valid = (count != '0);
  assign full = (count == CW'(DEPTH));
  assign head = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      unique case ({push, pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/fpsm_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
module fpsm_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire fpsm_pkg::entry_t head,
  input  wire logic             head_valid,
  output logic                  pop,
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  output logic [63:0]           m_tdata,
  output logic                  m_tuser,
  output logic                  m_tlast
);

  localparam int POS_W = fpsm_pkg::POS_W;

  logic [POS_W-1:0] hit_total;
  logic [POS_W-1:0] count_next;

  assign pop = head_valid && (!m_tvalid || m_tready);

  // saturating match count
  always_comb begin
    count_next = hit_total;
    if (head.hit && hit_total != '1) begin
      count_next = hit_total + POS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      hit_total <= '0;
    end else begin
      if (pop) begin
        m_tvalid <= 1'b1;
        hit_total <= head.last ? '0 : count_next;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      m_tdata <= {count_next, head.offset};
      m_tuser <= head.hit;
      m_tlast <= head.last;
    end
  end

endmodule
`default_nettype wire
